>>> rtl/core/ssr_pkg.sv
// Shared constants and register codes for the stream substring replacer.
`default_nettype none

package ssr_pkg;

    localparam int DATA_W          = 8;
    localparam int CFG_W           = 64;
    localparam int LEN_W           = 4;
    localparam int CFG_IDX_W       = 2;

    localparam int MAX_NEEDLE_DEF  = 8;
    localparam int MAX_REPL_DEF    = 8;

    localparam logic [CFG_W-1:0] NEEDLE_BYTES_RST = CFG_W'(64'h2C);
    localparam logic [LEN_W-1:0] NEEDLE_LEN_RST   = LEN_W'(4'd1);
    localparam logic [CFG_W-1:0] REPL_BYTES_RST   = CFG_W'(64'h0A2C);
    localparam logic [LEN_W-1:0] REPL_LEN_RST     = LEN_W'(4'd2);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEEDLE_BYTES = 2'd0,
        CFG_NEEDLE_LEN   = 2'd1,
        CFG_REPL_BYTES   = 2'd2,
        CFG_REPL_LEN     = 2'd3
    } t_cfg_idx;

endpackage

`default_nettype wire

>>> rtl/core/stream_substring_replace_top.sv
// Streaming find-and-replace: one text byte per request, bursts of result bytes out.
//
// Input channel: i_text_valid / o_text_stall carry one text byte and an end-of-text
// flag per request. Output channel: o_res_valid / i_res_stall carry one result byte
// per request with byte_valid, text_done and run_last flags.
// Configuration: write i_cfg_data to register i_cfg_index when i_cfg_we is high
// (0 needle bytes, 1 needle length, 2 replacement bytes, 3 replacement length).
// Write only while the block is idle.
// The first result of a request passes through the holding slot, then the drain register.
// Throughput: one request per cycle while each request causes at most one result
// and the receiver does not stall. A request that causes several results holds
// the output until all are taken; the drain register is the one-result-per-cycle
// port that sets this, and a holding slot in front of it lets the next request
// enter while a burst still drains.
// Reset (synchronous, active low) empties the window and both result slots and
// restores the default job: ',' becomes ",\n".
// When the receiver stalls, the current result holds; the holding slot takes one
// more request, then o_text_stall rises until the drain register frees up.
`default_nettype none

module stream_substring_replace_top
    import ssr_pkg::*;
#(
    parameter int MAX_NEEDLE      = MAX_NEEDLE_DEF,
    parameter int MAX_REPLACEMENT = MAX_REPL_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration write port
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    // text request channel
    input  wire logic                 i_text_valid,
    output logic                      o_text_stall,
    input  wire logic [DATA_W-1:0]    i_text_byte,
    input  wire logic                 i_end_of_text,
    // result request channel
    output logic                      o_res_valid,
    input  wire logic                 i_res_stall,
    output logic [DATA_W-1:0]         o_out_byte,
    output logic                      o_byte_valid,
    output logic                      o_text_done,
    output logic                      o_run_last
);

    localparam int BURST_D = (MAX_NEEDLE > MAX_REPLACEMENT) ? MAX_NEEDLE : MAX_REPLACEMENT;
    localparam int FILL_W  = $clog2(MAX_NEEDLE + 1);
    localparam int CNT_W   = $clog2(BURST_D + 1);

    typedef struct packed {
        logic [BURST_D-1:0][DATA_W-1:0] bytes;
        logic [CNT_W-1:0]               cnt;
        logic                           bvalid;
        logic                           done;
    } t_burst;

    // configuration registers
    logic [CFG_W-1:0] r_needle_bytes;
    logic [LEN_W-1:0] r_needle_len;
    logic [CFG_W-1:0] r_repl_bytes;
    logic [LEN_W-1:0] r_repl_len;

    // window of bytes not yet sent, entry 0 oldest
    logic [MAX_NEEDLE-1:0][DATA_W-1:0] r_win, n_win;
    logic [FILL_W-1:0]                 r_fill, n_fill;

    // holding slot and drain register
    logic   r_a_full, n_a_full;
    t_burst r_a, n_a;
    logic [CNT_W-1:0]               r_b_left, n_b_left;
    logic [BURST_D-1:0][DATA_W-1:0] r_b_bytes, n_b_bytes;
    logic                           r_b_bvalid, n_b_bvalid;
    logic                           r_b_done, n_b_done;

    logic accept, take, b_free, a_move;

    // per-request datapath
    logic [FILL_W-1:0]                 nlen, f1;
    logic [CNT_W-1:0]                  rlen;
    logic [MAX_NEEDLE-1:0][DATA_W-1:0] w;
    logic                              append, match, do_match, do_shift;
    t_burst                            burst;

    // ---------------------------------------------------------------
    // Configuration
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_needle_bytes <= NEEDLE_BYTES_RST;
            r_needle_len   <= NEEDLE_LEN_RST;
            r_repl_bytes   <= REPL_BYTES_RST;
            r_repl_len     <= REPL_LEN_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_NEEDLE_BYTES: r_needle_bytes <= i_cfg_data;
                CFG_NEEDLE_LEN:   r_needle_len   <= i_cfg_data[LEN_W-1:0];
                CFG_REPL_BYTES:   r_repl_bytes   <= i_cfg_data;
                CFG_REPL_LEN:     r_repl_len     <= i_cfg_data[LEN_W-1:0];
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Handshake
    // ---------------------------------------------------------------
    assign o_res_valid  = (r_b_left != '0);
    assign take         = o_res_valid && !i_res_stall;
    assign b_free       = (r_b_left == '0) || ((r_b_left == CNT_W'(1)) && take);
    assign a_move       = r_a_full && b_free;
    assign o_text_stall = r_a_full && !a_move;
    assign accept       = i_text_valid && !o_text_stall;

    // ---------------------------------------------------------------
    // Window update and result burst for the incoming byte
    // ---------------------------------------------------------------
    always_comb begin
        // clamp the needle length to 1..MAX_NEEDLE, the replacement to MAX_REPLACEMENT
        if (r_needle_len == '0) begin
            nlen = FILL_W'(1);
        end else if (r_needle_len > LEN_W'(MAX_NEEDLE)) begin
            nlen = FILL_W'(MAX_NEEDLE);
        end else begin
            nlen = FILL_W'(r_needle_len);
        end
        if (r_repl_len > LEN_W'(MAX_REPLACEMENT)) begin
            rlen = CNT_W'(MAX_REPLACEMENT);
        end else begin
            rlen = CNT_W'(r_repl_len);
        end

        // append the new byte behind the pending ones
        append = (r_fill < FILL_W'(MAX_NEEDLE));
        for (int i = 0; i < MAX_NEEDLE; i++) begin
            w[i] = (append && (r_fill == FILL_W'(i))) ? i_text_byte : r_win[i];
        end
        f1 = append ? r_fill + FILL_W'(1) : r_fill;

        // parallel compare against the needle
        match = 1'b1;
        for (int i = 0; i < MAX_NEEDLE; i++) begin
            if ((FILL_W'(i) < nlen) && (w[i] != r_needle_bytes[DATA_W*i +: DATA_W])) begin
                match = 1'b0;
            end
        end

        priority if (f1 > nlen) begin
            do_match = 1'b0;
            do_shift = 1'b1;
        end else if (f1 == nlen) begin
            do_match = match;
            do_shift = !match;
        end else begin
            // window still short of the needle: hold
            do_match = 1'b0;
            do_shift = 1'b0;
        end

        // burst contents: the replacement on a match, else the window from its oldest byte
        burst.bytes = '0;
        for (int i = 0; i < BURST_D; i++) begin
            if (do_match) begin
                if (i < MAX_REPLACEMENT) begin
                    burst.bytes[i] = r_repl_bytes[DATA_W*i +: DATA_W];
                end
            end else if (i < MAX_NEEDLE) begin
                burst.bytes[i] = w[i];
            end
        end
        burst.bvalid = 1'b1;
        burst.done   = i_end_of_text;

        n_win = w;
        if (do_match) begin
            burst.cnt = rlen;
            n_fill    = '0;
        end else if (do_shift) begin
            // send the oldest byte; at end of text flush the rest behind it
            for (int i = 0; i < MAX_NEEDLE - 1; i++) begin
                n_win[i] = w[i+1];
            end
            burst.cnt = i_end_of_text ? CNT_W'(f1) : CNT_W'(1);
            n_fill    = i_end_of_text ? '0 : f1 - FILL_W'(1);
        end else begin
            burst.cnt = i_end_of_text ? CNT_W'(f1) : '0;
            n_fill    = i_end_of_text ? '0 : f1;
        end

        // end of text with nothing to send: one marker result without a byte
        if (i_end_of_text && (burst.cnt == '0)) begin
            burst.cnt      = CNT_W'(1);
            burst.bvalid   = 1'b0;
            burst.bytes[0] = '0;
        end
    end

    // ---------------------------------------------------------------
    // Holding slot and drain register next state
    // ---------------------------------------------------------------
    always_comb begin
        n_a_full = (r_a_full && !a_move) || (accept && (burst.cnt != '0));
        n_a      = (accept && (burst.cnt != '0)) ? burst : r_a;

        n_b_left   = r_b_left;
        n_b_bytes  = r_b_bytes;
        n_b_bvalid = r_b_bvalid;
        n_b_done   = r_b_done;
        if (a_move) begin
            n_b_left   = r_a.cnt;
            n_b_bytes  = r_a.bytes;
            n_b_bvalid = r_a.bvalid;
            n_b_done   = r_a.done;
        end else if (take) begin
            // advance to the next byte of the burst
            n_b_left = r_b_left - CNT_W'(1);
            for (int i = 0; i < BURST_D - 1; i++) begin
                n_b_bytes[i] = r_b_bytes[i+1];
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_a_full <= 1'b0;
            r_b_left <= '0;
        end else begin
            if (accept) begin
                r_fill <= n_fill;
            end
            r_a_full <= n_a_full;
            r_b_left <= n_b_left;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_win <= n_win;
        end
        r_a        <= n_a;
        r_b_bytes  <= n_b_bytes;
        r_b_bvalid <= n_b_bvalid;
        r_b_done   <= n_b_done;
    end

    assign o_out_byte   = r_b_bytes[0];
    assign o_byte_valid = r_b_bvalid;
    assign o_run_last   = (r_b_left == CNT_W'(1));
    assign o_text_done  = r_b_done && (r_b_left == CNT_W'(1));

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // between requests the window always has room for the next byte
    a_fill_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < FILL_W'(MAX_NEEDLE))
        else $error("window fill reached its depth between requests");

    a_burst_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_left <= CNT_W'(BURST_D))
        else $error("drain count exceeds burst depth");

    // a result without a byte only marks the end of a text, alone in its burst
    a_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_byte_valid) |-> (o_text_done && o_run_last))
        else $error("byteless result that is not an end marker");

    // a full holding slot moves on as soon as the drain register frees up
    a_slot_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_full && (r_b_left == '0)) |=> (r_b_left != '0))
        else $error("holding slot not transferred to an empty drain register");

endmodule

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the streaming find-and-replace block.
module tb_top;
    import ssr_pkg::*;

    localparam int MAX_N         = MAX_NEEDLE_DEF;
    localparam int MAX_R         = MAX_REPL_DEF;
    localparam int SETTLE_CYCLES = 4;      // allow margin after the last due result
    localparam int TAIL_CYCLES   = 10;
    localparam int N_DIR         = 34;
    localparam int N_PHASES      = 8;
    localparam int PHASE_ITEMS   = 37;
    localparam int MAX_ERR_PRINT = 50;

    // ------------------------------------------------------------------
    // DUT signals, all inputs known from time zero
    // ------------------------------------------------------------------
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [CFG_W-1:0]     i_cfg_data    = '0;
    logic                 i_text_valid  = 1'b0;
    logic [DATA_W-1:0]    i_text_byte   = '0;
    logic                 i_end_of_text = 1'b0;
    logic                 i_res_stall   = 1'b0;
    logic                 o_text_stall;
    logic                 o_res_valid;
    logic [DATA_W-1:0]    o_out_byte;
    logic                 o_byte_valid;
    logic                 o_text_done;
    logic                 o_run_last;

    stream_substring_replace_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_text_valid  (i_text_valid),
        .o_text_stall  (o_text_stall),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .o_res_valid   (o_res_valid),
        .i_res_stall   (i_res_stall),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_text_done   (o_text_done),
        .o_run_last    (o_run_last)
    );

    // 10 ns period: high half, then low half
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Types
    // ------------------------------------------------------------------
    typedef struct {
        logic [DATA_W-1:0] ob;
        logic              bv;
        logic              done;
        logic              last;
    } out_res_t;

    // One text request; typed rows carry their results written out by hand
    typedef struct {
        logic [DATA_W-1:0] tb;
        logic              eot;
        bit                typed;
        int                xcnt;
        logic [CFG_W-1:0]  xdata;
        bit                xmark;
    } text_req_t;

    typedef struct {
        bit               is_cfg;
        t_cfg_idx         idx;
        logic [CFG_W-1:0] val;
        text_req_t        req;
    } stim_row_t;

    // ------------------------------------------------------------------
    // Shadow copy of the job and the pending window
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]  m_needle = NEEDLE_BYTES_RST;
    logic [LEN_W-1:0]  m_nlen   = NEEDLE_LEN_RST;
    logic [CFG_W-1:0]  m_repl   = REPL_BYTES_RST;
    logic [LEN_W-1:0]  m_rlen   = REPL_LEN_RST;
    logic [DATA_W-1:0] win [MAX_N] = '{default: '0};
    int unsigned       win_fill = 0;

    text_req_t requests_in_flight [$];
    out_res_t  step_results [$];
    out_res_t  due_results [$];

    int err_cnt       = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;

    // Send the oldest window byte and shift the rest down
    function automatic void shift_oldest();
        out_res_t r;
        int       i;
        r.ob   = win[0];
        r.bv   = 1'b1;
        r.done = 1'b0;
        r.last = 1'b0;
        step_results.push_back(r);
        for (i = 1; i < MAX_N; i++)
            if (i < win_fill) win[i-1] = win[i];
        win_fill--;
    endfunction

    // Advance the window by one text byte; leave the results it causes in step_results
    function automatic void predict_replace(input logic [DATA_W-1:0] tb, input logic eot);
        int unsigned nl;
        int unsigned rl;
        bit          hit;
        out_res_t    r;
        int          i;
        step_results.delete();
        // clamp the lengths: zero needle counts as one, both saturate at the maximum
        nl = (m_nlen == 0) ? 1 : ((m_nlen > MAX_N) ? MAX_N : m_nlen);
        rl = (m_rlen > MAX_R) ? MAX_R : m_rlen;

        if (win_fill < MAX_N) begin
            win[win_fill] = tb;
            win_fill++;
        end

        if (win_fill > nl) begin
            // needle shortened mid-text: drain without comparing
            shift_oldest();
        end else if (win_fill == nl) begin
            hit = 1'b1;
            for (i = 0; i < nl; i++)
                if (win[i] != m_needle[DATA_W*i +: DATA_W]) hit = 1'b0;
            if (hit) begin
                for (i = 0; i < rl; i++) begin
                    r.ob   = m_repl[DATA_W*i +: DATA_W];
                    r.bv   = 1'b1;
                    r.done = 1'b0;
                    r.last = 1'b0;
                    step_results.push_back(r);
                end
                win_fill = 0;
            end else begin
                shift_oldest();
            end
        end

        if (eot) begin
            while (win_fill > 0) shift_oldest();
            // nothing left to send: mark the end with an empty result
            if (step_results.size() == 0) begin
                r.ob   = '0;
                r.bv   = 1'b0;
                r.done = 1'b0;
                r.last = 1'b0;
                step_results.push_back(r);
            end
            step_results[step_results.size()-1].done = 1'b1;
        end
        if (step_results.size() > 0) step_results[step_results.size()-1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard: predict on each accepted request, then check each result.
    // Both in one block so a push and a pop never race within a step.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : scoreboard
        text_req_t req;
        out_res_t  got;
        out_res_t  want;
        int        j;
        if (i_rst_n && i_text_valid && !o_text_stall) begin
            req = requests_in_flight.pop_front();
            predict_replace(req.tb, req.eot);
            // typed rows replace the prediction; the window still advances
            if (req.typed) begin
                step_results.delete();
                for (j = 0; j < req.xcnt; j++) begin
                    want.ob   = req.xmark ? '0 : req.xdata[DATA_W*j +: DATA_W];
                    want.bv   = !req.xmark;
                    want.done = req.eot && (j == req.xcnt - 1);
                    want.last = (j == req.xcnt - 1);
                    step_results.push_back(want);
                end
            end
            foreach (step_results[k]) due_results.push_back(step_results[k]);
        end

        if (i_rst_n && o_res_valid && !i_res_stall) begin
            got = '{o_out_byte, o_byte_valid, o_text_done, o_run_last};
            if (due_results.size() == 0) begin
                err_cnt++;
                if (err_cnt <= MAX_ERR_PRINT)
                    $display("%0t unexpected result: byte %02h valid %0b done %0b last %0b",
                             $time, got.ob, got.bv, got.done, got.last);
            end else begin
                want = due_results.pop_front();
                if (got.ob !== want.ob || got.bv !== want.bv ||
                    got.done !== want.done || got.last !== want.last) begin
                    err_cnt++;
                    if (err_cnt <= MAX_ERR_PRINT)
                        $display({"%0t result mismatch: expected byte %02h valid %0b done %0b ",
                                  "last %0b, got byte %02h valid %0b done %0b last %0b"},
                                 $time, want.ob, want.bv, want.done, want.last,
                                 got.ob, got.bv, got.done, got.last);
                end
            end
        end
    end

    // Receiver back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        i_res_stall <= ($urandom_range(99) < stall_pct);
    end

    // ------------------------------------------------------------------
    // Driver helpers
    // ------------------------------------------------------------------
    function automatic stim_row_t text_row(input logic [DATA_W-1:0] tb, input logic eot,
                                           input bit typed, input int xcnt,
                                           input logic [CFG_W-1:0] xdata, input bit xmark);
        stim_row_t r;
        r.is_cfg = 1'b0;
        r.idx    = CFG_NEEDLE_BYTES;
        r.val    = '0;
        r.req    = '{tb, eot, typed, xcnt, xdata, xmark};
        return r;
    endfunction

    function automatic stim_row_t reg_row(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        stim_row_t r;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.val    = val;
        r.req    = '{'0, 1'b0, 1'b0, 0, '0, 1'b0};
        return r;
    endfunction

    // Offer one text request, with random idle cycles ahead of it; return once accepted
    task automatic send_request(input text_req_t req);
        while ($urandom_range(99) < send_idle_pct) begin
            i_text_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_text_valid  <= 1'b1;
        i_text_byte   <= req.tb;
        i_end_of_text <= req.eot;
        requests_in_flight.push_back(req);
        do @(posedge i_clk); while (o_text_stall);
    endtask

    // Drop valid, wait for every due result, then let the pipeline settle
    task automatic wait_quiet();
        i_text_valid <= 1'b0;
        @(posedge i_clk);
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write one register; the caller lowers the write enable afterwards
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            CFG_NEEDLE_BYTES: m_needle = val;
            CFG_NEEDLE_LEN:   m_nlen   = val[LEN_W-1:0];
            CFG_REPL_BYTES:   m_repl   = val;
            CFG_REPL_LEN:     m_rlen   = val[LEN_W-1:0];
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        stim_row_t         dir_rows [N_DIR];
        text_req_t         req;
        logic [DATA_W-1:0] alpha [4];
        logic [DATA_W-1:0] txt_q [$];
        logic [CFG_W-1:0]  nb;
        logic [CFG_W-1:0]  rb;
        logic [LEN_W-1:0]  nl_v;
        logic [LEN_W-1:0]  rl_v;
        int                nl_eff;
        int                n_items;
        int                plen;
        int                pick;
        int                k;
        int                i;
        int                ph;

        dir_rows = '{
            // default job ',' -> ",\n": plain byte, match, zero byte, last byte
            text_row(8'h61, 1'b0, 1'b1, 1, 64'h61,   1'b0),
            text_row(8'h2C, 1'b0, 1'b1, 2, 64'h0A2C, 1'b0),
            text_row(8'h00, 1'b0, 1'b1, 1, 64'h00,   1'b0),
            text_row(8'hFF, 1'b1, 1'b1, 1, 64'hFF,   1'b0),
            // delete matches: a match on the last byte leaves only the end marker
            reg_row(CFG_REPL_LEN, 64'd0),
            text_row(8'h2C, 1'b1, 1'b1, 1, 64'h0,    1'b1),
            // "abc" -> "XY", then a near miss flushed by end-of-text
            reg_row(CFG_NEEDLE_BYTES, 64'h636261),
            reg_row(CFG_NEEDLE_LEN,   64'd3),
            reg_row(CFG_REPL_BYTES,   64'h5958),
            reg_row(CFG_REPL_LEN,     64'd2),
            text_row(8'h61, 1'b0, 1'b0, 0, '0, 1'b0),
            text_row(8'h62, 1'b0, 1'b0, 0, '0, 1'b0),
            text_row(8'h63, 1'b0, 1'b0, 0, '0, 1'b0),
            text_row(8'h61, 1'b0, 1'b0, 0, '0, 1'b0),
            text_row(8'h62, 1'b0, 1'b0, 0, '0, 1'b0),
            text_row(8'h64, 1'b1, 1'b0, 0, '0, 1'b0),
            // full-size needle and replacement, lengths written above range
            reg_row(CFG_NEEDLE_BYTES, 64'hFFFF_FFFF_FFFF_FFFF),
            reg_row(CFG_NEEDLE_LEN,   64'd15),
            reg_row(CFG_REPL_BYTES,   64'h0123_4567_89AB_CDEF),
            reg_row(CFG_REPL_LEN,     64'd15),
            text_row(8'hFF, 1'b0, 1'b0, 0, '0, 1'b0),
            text_row(8'hFF, 1'b0, 1'b0, 0, '0, 1'b0),
            text_row(8'hFF, 1'b0, 1'b0, 0, '0, 1'b0),
            text_row(8'hFF, 1'b0, 1'b0, 0, '0, 1'b0),
            text_row(8'hFF, 1'b0, 1'b0, 0, '0, 1'b0),
            text_row(8'hFF, 1'b0, 1'b0, 0, '0, 1'b0),
            text_row(8'hFF, 1'b0, 1'b0, 0, '0, 1'b0),
            text_row(8'hFF, 1'b0, 1'b1, 8, 64'h0123_4567_89AB_CDEF, 1'b0),
            // fill three bytes, then shrink the needle to length zero (counts as one)
            text_row(8'hFF, 1'b0, 1'b0, 0, '0, 1'b0),
            text_row(8'hFF, 1'b0, 1'b0, 0, '0, 1'b0),
            text_row(8'hFF, 1'b0, 1'b0, 0, '0, 1'b0),
            reg_row(CFG_NEEDLE_LEN, 64'd0),
            text_row(8'hFE, 1'b0, 1'b0, 0, '0, 1'b0),
            text_row(8'hFF, 1'b1, 1'b0, 0, '0, 1'b0)
        };

        // hold reset once at the start, then release it
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, no idling on either side
        foreach (dir_rows[r]) begin
            if (dir_rows[r].is_cfg) begin
                wait_quiet();
                write_reg(dir_rows[r].idx, dir_rows[r].val);
                i_cfg_we <= 1'b0;
            end else begin
                send_request(dir_rows[r].req);
            end
        end

        // random phases: new job and idling mode per phase
        for (ph = 0; ph < N_PHASES; ph++) begin
            wait_quiet();
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 46; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 46; end
                default: begin send_idle_pct = 27; stall_pct = 27; end
            endcase

            // first phases hit the length extremes, later ones pick freely
            case (ph)
                0: begin nl_v = 4'd1;  rl_v = 4'd0;  end
                1: begin nl_v = 4'd8;  rl_v = 4'd8;  end
                2: begin nl_v = 4'd0;  rl_v = 4'd15; end
                3: begin nl_v = 4'd15; rl_v = 4'd1;  end
                default: begin
                    nl_v = ($urandom_range(3) == 0) ? LEN_W'($urandom_range(15))
                                                    : LEN_W'($urandom_range(1, 4));
                    rl_v = LEN_W'($urandom_range(9));
                end
            endcase
            nl_eff = (nl_v == 0) ? 1 : ((nl_v > MAX_N) ? MAX_N : nl_v);

            // small alphabet so partial matches and overlaps show up often
            for (i = 0; i < 4; i++) alpha[i] = DATA_W'($urandom_range(255));
            if ($urandom_range(1) == 1) begin
                nb = {$urandom, $urandom};
            end else begin
                for (i = 0; i < MAX_N; i++) nb[DATA_W*i +: DATA_W] = alpha[$urandom_range(3)];
            end
            rb = {$urandom, $urandom};

            write_reg(CFG_NEEDLE_BYTES, nb);
            write_reg(CFG_NEEDLE_LEN,   CFG_W'(nl_v));
            write_reg(CFG_REPL_BYTES,   rb);
            write_reg(CFG_REPL_LEN,     CFG_W'(rl_v));
            i_cfg_we <= 1'b0;

            n_items = 0;
            while (n_items < PHASE_ITEMS) begin
                // build a text from whole needles, needle prefixes and noise
                txt_q.delete();
                plen = $urandom_range(1, 16);
                while (txt_q.size() < plen) begin
                    pick = $urandom_range(9);
                    if (pick < 4) begin
                        for (i = 0; i < nl_eff; i++) txt_q.push_back(nb[DATA_W*i +: DATA_W]);
                    end else if (pick < 6) begin
                        k = $urandom_range(nl_eff - 1);
                        for (i = 0; i < k; i++) txt_q.push_back(nb[DATA_W*i +: DATA_W]);
                    end else if (pick < 9) begin
                        txt_q.push_back(alpha[$urandom_range(3)]);
                    end else begin
                        txt_q.push_back(DATA_W'($urandom_range(255)));
                    end
                end
                // most texts end with end-of-text; the rest run into the next one
                foreach (txt_q[t]) begin
                    req.tb    = txt_q[t];
                    req.eot   = (t == txt_q.size() - 1) && ($urandom_range(7) != 0);
                    req.typed = 1'b0;
                    req.xcnt  = 0;
                    req.xdata = '0;
                    req.xmark = 1'b0;
                    send_request(req);
                    n_items++;
                end
                // now and then hold off until every result is out
                if ($urandom_range(29) == 0) wait_quiet();
            end
        end

        // drain, then give the pipeline time to show any stray result
        wait_quiet();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_cnt == 0 && due_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run
    initial begin : watchdog
        #3_000_000;
        $display("%0t timeout with %0d results outstanding", $time, due_results.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
